// File: hw/rtl/csft_pkg.sv
// csft_pkg: shared types and constants for the clock sweep frame table
// no dependencies; used by clock_sweep_frame_table_top
`timescale 1ns / 1ps
package csft_pkg;

   localparam int NUM_FRAMES_DEF = 1024;
   localparam int USAGE_CAP_DEF  = 5;

   localparam int FUNC_W  = 3;
   localparam int PID_W   = 10;
   localparam int CNT_W   = 11;
   localparam int CFG_W   = 11;
   localparam int STAT_W  = 2;
   localparam int PIN_W   = 8;
   localparam int USAGE_W = 3;
   localparam logic [PIN_W-1:0] PIN_MAX = 8'd255;

   typedef enum logic [FUNC_W-1:0] {
      FN_ACCESS = 3'd0,
      FN_UNPIN  = 3'd1,
      FN_DIRTY  = 3'd2,
      FN_CLEAN  = 3'd3,
      FN_SWEEP  = 3'd4,
      FN_EVICT  = 3'd5,
      FN_DRAIN  = 3'd6,
      FN_NOP    = 3'd7
   } func_type;

   typedef enum logic [STAT_W-1:0] {
      RS_OK     = 2'd0,
      RS_ABSENT = 2'd1,
      RS_DIRTY  = 2'd2,
      RS_PINNED = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_OP,
      S_DRAIN,
      S_COPY,
      S_SW_RD,
      S_SW_EX
   } state_type;

   typedef struct packed {
      logic               res;
      logic               dirty;
      logic               queued;
      logic               prot;
      logic               member;
      logic [PIN_W-1:0]   pin;
      logic [USAGE_W-1:0] usage;
   } entry_type;

endpackage

// File: hw/rtl/clock_sweep_frame_table_top.sv
// clock_sweep_frame_table_top: page frame table with gclock sweep, one entry memory
// depends on csft_pkg
`timescale 1ns / 1ps
//
//   channel   ports                               beat taken when
//   request   start, busy, req_*                  start && !busy
//   response  rsp_valid, rsp_*                    rsp_valid (one cycle, no stall)
//   config    csr_we, csr_wdata                   csr_we
//
// table ops (access, unpin, mark dirty, written clean, evict): one entry read
// then at most one write back, response the cycle after
// drain scans entries from id 0, one per cycle until the first queued page or the last id
// sweep copies resident to member for all NUM_FRAMES entries (one per cycle),
// then visits one id per cycle from the hand until the budget is reclaimed or the step limit runs out
// after reset a clearing pass over all NUM_FRAMES entries holds busy high
// responses cannot be stalled; config writes are taken at any time, but only a larger bound is kept
module clock_sweep_frame_table_top #(
   parameter int NUM_FRAMES = csft_pkg::NUM_FRAMES_DEF,
   parameter int USAGE_CAP  = csft_pkg::USAGE_CAP_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [csft_pkg::FUNC_W-1:0] req_func,
   input  logic [csft_pkg::PID_W-1:0]  req_page_id,
   input  logic                        req_mark_dirty,
   input  logic                        req_bump_usage,
   input  logic                        req_take_pin,
   input  logic                        req_protected_kind,
   input  logic [csft_pkg::CNT_W-1:0]  req_budget,
   output logic                        rsp_valid,
   output logic [csft_pkg::STAT_W-1:0] rsp_status,
   output logic                        rsp_hit,
   output logic [csft_pkg::PID_W-1:0]  rsp_page_out,
   output logic                        rsp_page_out_valid,
   output logic [csft_pkg::CNT_W-1:0]  rsp_count,
   input  logic                        csr_we,
   input  logic [csft_pkg::CFG_W-1:0]  csr_wdata
);

   localparam int ID_W   = $clog2(NUM_FRAMES);
   localparam int TOT_W  = ID_W + 1;
   localparam int CMP_W  = (TOT_W > csft_pkg::CNT_W) ? TOT_W : csft_pkg::CNT_W;
   localparam int STEP_W = TOT_W + 3;
   localparam logic [ID_W-1:0] LAST_ID = ID_W'(NUM_FRAMES - 1);

   // entry memory, registered read
   csft_pkg::entry_type mem [NUM_FRAMES];
   csft_pkg::entry_type rd_data_ff;
   logic [ID_W-1:0]     rd_addr;
   logic                wr_en;
   logic [ID_W-1:0]     wr_addr;
   csft_pkg::entry_type wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // control and latched request
   csft_pkg::state_type state_ff, state_in;
   logic [ID_W-1:0]  addr_ff, addr_in;
   logic [TOT_W-1:0] total_ff, total_in;
   logic [TOT_W-1:0] hand_ff, hand_in;
   logic [csft_pkg::CFG_W-1:0] first_ff;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic [TOT_W-1:0]  recl_ff, recl_in;

   csft_pkg::func_type func_ff, func_in;
   logic             ok_ff, ok_in;
   logic             mdirty_ff, mdirty_in, bump_ff, bump_in;
   logic             tpin_ff, tpin_in, prot_ff, prot_in;
   logic [csft_pkg::CNT_W-1:0] budget_ff, budget_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   csft_pkg::status_type        rsp_status_ff, rsp_status_in;
   logic                        rsp_hit_ff, rsp_hit_in;
   logic [csft_pkg::PID_W-1:0]  rsp_pout_ff, rsp_pout_in;
   logic                        rsp_pvalid_ff, rsp_pvalid_in;
   logic [csft_pkg::CNT_W-1:0]  rsp_count_ff, rsp_count_in;

   // sweep start point and next id
   logic [ID_W-1:0] p_start, p_next;
   assign p_start = (CMP_W'(hand_ff) < CMP_W'(NUM_FRAMES)) ? hand_ff[ID_W-1:0] : '0;
   assign p_next  = (addr_ff == LAST_ID) ? '0 : addr_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= csft_pkg::S_CLEAR;
         addr_ff      <= '0;
         total_ff     <= '0;
         hand_ff      <= '0;
         first_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         total_ff     <= total_in;
         hand_ff      <= hand_in;
         rsp_valid_ff <= rsp_valid_in;
         // bound only rises
         if (csr_we && (csr_wdata > first_ff)) begin
            first_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      steps_ff      <= steps_in;
      recl_ff       <= recl_in;
      func_ff       <= func_in;
      ok_ff         <= ok_in;
      mdirty_ff     <= mdirty_in;
      bump_ff       <= bump_in;
      tpin_ff       <= tpin_in;
      prot_ff       <= prot_in;
      budget_ff     <= budget_in;
      rsp_status_ff <= rsp_status_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_pout_ff   <= rsp_pout_in;
      rsp_pvalid_ff <= rsp_pvalid_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_comb begin
      csft_pkg::entry_type e;
      logic res;
      logic sw_done;
      e        = rd_data_ff;
      res      = ok_ff && e.res;
      sw_done  = 1'b0;
      state_in = state_ff;
      addr_in  = addr_ff;
      total_in = total_ff;
      hand_in  = hand_ff;
      steps_in = steps_ff;
      recl_in  = recl_ff;
      func_in  = func_ff;
      ok_in    = ok_ff;
      mdirty_in = mdirty_ff;
      bump_in  = bump_ff;
      tpin_in  = tpin_ff;
      prot_in  = prot_ff;
      budget_in = budget_ff;
      rd_addr  = addr_ff;
      wr_en    = 1'b0;
      wr_addr  = addr_ff;
      wr_data  = e;
      rsp_valid_in  = 1'b0;
      rsp_status_in = csft_pkg::RS_OK;
      rsp_hit_in    = 1'b0;
      rsp_pout_in   = '0;
      rsp_pvalid_in = 1'b0;
      rsp_count_in  = csft_pkg::CNT_W'(total_ff);

      case (state_ff)
         csft_pkg::S_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = '0;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == LAST_ID) begin
               state_in = csft_pkg::S_IDLE;
            end
         end

         csft_pkg::S_IDLE: begin
            rd_addr = ID_W'(req_page_id);
            if (start) begin
               func_in   = csft_pkg::func_type'(req_func);
               ok_in     = CMP_W'(req_page_id) < CMP_W'(NUM_FRAMES);
               mdirty_in = req_mark_dirty;
               bump_in   = req_bump_usage;
               tpin_in   = req_take_pin;
               prot_in   = req_protected_kind;
               budget_in = req_budget;
               addr_in   = ID_W'(req_page_id);
               case (csft_pkg::func_type'(req_func))
                  csft_pkg::FN_SWEEP: begin
                     if (req_budget == '0 || total_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_count_in = '0;
                     end else begin
                        state_in = csft_pkg::S_COPY;
                        addr_in  = '0;
                        rd_addr  = '0;
                        recl_in  = '0;
                        steps_in = STEP_W'(total_ff) * STEP_W'(USAGE_CAP + 1);
                     end
                  end
                  csft_pkg::FN_DRAIN: begin
                     state_in = csft_pkg::S_DRAIN;
                     addr_in  = '0;
                     rd_addr  = '0;
                  end
                  default: begin
                     state_in = csft_pkg::S_OP;
                  end
               endcase
            end
         end

         // one entry read-modify-write
         csft_pkg::S_OP: begin
            state_in     = csft_pkg::S_IDLE;
            rsp_valid_in = 1'b1;
            case (func_ff)
               csft_pkg::FN_ACCESS: begin
                  if (!ok_ff) begin
                     rsp_status_in = csft_pkg::RS_ABSENT;
                  end else begin
                     wr_en = 1'b1;
                     if (e.res) begin
                        rsp_hit_in = 1'b1;
                        if (mdirty_ff) begin
                           wr_data.dirty = 1'b1;
                        end
                        if (bump_ff && e.usage < csft_pkg::USAGE_W'(USAGE_CAP)) begin
                           wr_data.usage = e.usage + 1'b1;
                        end
                     end else begin
                        wr_data.res    = 1'b1;
                        wr_data.dirty  = mdirty_ff;
                        wr_data.queued = 1'b0;
                        wr_data.usage  = '0;
                        wr_data.pin    = '0;
                        total_in       = total_ff + 1'b1;
                     end
                     wr_data.prot = prot_ff;
                     if (tpin_ff && wr_data.pin != csft_pkg::PIN_MAX) begin
                        wr_data.pin = wr_data.pin + 1'b1;
                     end
                  end
               end
               csft_pkg::FN_UNPIN, csft_pkg::FN_DIRTY, csft_pkg::FN_CLEAN,
               csft_pkg::FN_EVICT: begin
                  if (!res) begin
                     rsp_status_in = csft_pkg::RS_ABSENT;
                  end else begin
                     wr_en = 1'b1;
                     case (func_ff)
                        csft_pkg::FN_UNPIN: begin
                           if (e.pin != '0) begin
                              wr_data.pin = e.pin - 1'b1;
                           end
                        end
                        csft_pkg::FN_DIRTY: begin
                           wr_data.dirty = 1'b1;
                        end
                        csft_pkg::FN_CLEAN: begin
                           wr_data.dirty  = 1'b0;
                           wr_data.queued = 1'b0;
                        end
                        default: begin
                           // evict clean: dirty checked before pins
                           if (e.dirty) begin
                              rsp_status_in = csft_pkg::RS_DIRTY;
                           end else if (e.pin != '0) begin
                              rsp_status_in = csft_pkg::RS_PINNED;
                           end else begin
                              wr_data.res   = 1'b0;
                              wr_data.prot  = 1'b0;
                              wr_data.usage = '0;
                              total_in      = total_ff - 1'b1;
                           end
                        end
                     endcase
                  end
               end
               default: begin
               end
            endcase
            rsp_count_in = csft_pkg::CNT_W'(total_in);
         end

         // scan from id 0 for the lowest queued page
         csft_pkg::S_DRAIN: begin
            if (e.queued) begin
               wr_en          = 1'b1;
               wr_data.queued = 1'b0;
               wr_data.dirty  = 1'b0;
               rsp_valid_in   = 1'b1;
               rsp_pout_in    = csft_pkg::PID_W'(addr_ff);
               rsp_pvalid_in  = 1'b1;
               state_in       = csft_pkg::S_IDLE;
            end else if (addr_ff == LAST_ID) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = csft_pkg::RS_ABSENT;
               state_in      = csft_pkg::S_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
               rd_addr = addr_ff + 1'b1;
            end
         end

         // load member bits from resident bits
         csft_pkg::S_COPY: begin
            wr_en          = 1'b1;
            wr_data.member = e.res;
            if (addr_ff == LAST_ID) begin
               state_in = csft_pkg::S_SW_RD;
               addr_in  = p_start;
            end else begin
               addr_in = addr_ff + 1'b1;
               rd_addr = addr_ff + 1'b1;
            end
         end

         csft_pkg::S_SW_RD: begin
            state_in = csft_pkg::S_SW_EX;
         end

         // one id per cycle; next read never hits the entry being written
         csft_pkg::S_SW_EX: begin
            addr_in = p_next;
            rd_addr = p_next;
            if (e.member) begin
               wr_en    = 1'b1;
               steps_in = steps_ff - 1'b1;
               if (e.res && e.pin == '0 && !e.prot &&
                   !(CMP_W'(addr_ff) < CMP_W'(first_ff))) begin
                  if (e.usage != '0) begin
                     wr_data.usage = e.usage - 1'b1;
                  end else if (e.dirty) begin
                     wr_data.queued = 1'b1;
                  end else begin
                     wr_data.res  = 1'b0;
                     wr_data.prot = 1'b0;
                     total_in     = total_ff - 1'b1;
                     recl_in      = recl_ff + 1'b1;
                     hand_in      = TOT_W'(addr_ff) + 1'b1;
                  end
               end
               sw_done = (steps_ff == STEP_W'(1)) ||
                         (CMP_W'(recl_in) == CMP_W'(budget_ff));
               if (sw_done) begin
                  rsp_valid_in = 1'b1;
                  rsp_count_in = csft_pkg::CNT_W'(recl_in);
                  state_in     = csft_pkg::S_IDLE;
               end
            end
         end

         default: begin
            state_in = csft_pkg::S_IDLE;
         end
      endcase
   end

   assign busy               = (state_ff != csft_pkg::S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_page_out       = rsp_pout_ff;
   assign rsp_page_out_valid = rsp_pvalid_ff;
   assign rsp_count          = rsp_count_ff;

endmodule
